/* design/mwm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared types and constants for the mecanum wheel mixer.
// ----------------------------------------------------------------------------
package mwm_pkg;

   // CSR register indexes
   localparam logic [1:0] CSR_DEADBAND_LEVEL  = 2'd0;
   localparam logic [1:0] CSR_MAGNITUDE_LIMIT = 2'd1;

   // CSR reset values, Q2.14
   localparam logic [14:0] DEADBAND_RESET = 15'd819;
   localparam logic [14:0] LIMIT_RESET    = 15'd16384;

   // 1.0 in Q2.14, sized for the wheel speed magnitudes
   localparam logic [16:0] ONE_Q14 = 17'd16384;

   // Diagonal lanes (x+y and y-x) and wheels
   localparam int unsigned LANES  = 2;
   localparam int unsigned WHEELS = 4;

   // Per-item side information carried down the long pipeline
   typedef struct packed {
      logic [15:0] turn;
      logic        neg_p;
      logic        neg_q;
   } side_type;

endpackage

/* design/mecanum_wheel_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer
// Mecanum drive inverse kinematics: strafe/forward/turn in, four wheel speeds
// out, all signed Q2.14, fully pipelined.
// ----------------------------------------------------------------------------
// One command is taken every clock cycle unless a result is held on the output.
// The depth is set by three bit-per-stage units: a 32-stage restoring divider
// that halves each squared diagonal term and, when clamping, scales it by
// limit^2/magnitude^2, a 16-stage square root, and a 15-stage divider that
// normalizes the speeds by the largest one when it exceeds 1.0. The whole
// pipeline advances together: when a result is held on the output because
// rsp_ready is low, req_ready drops in the same cycle and nothing inside moves.
// A configuration write reaches the datapath in the cycle after the write edge,
// since the squared thresholds are registered; writes are meant for an idle block.
module mecanum_wheel_mixer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_strafe_cmd,
   input  logic signed [15:0] req_forward_cmd,
   input  logic signed [15:0] req_turn_cmd,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_left_front_speed,
   output logic signed [15:0] rsp_left_back_speed,
   output logic signed [15:0] rsp_right_front_speed,
   output logic signed [15:0] rsp_right_back_speed,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_wdata
);

   localparam int unsigned DIV_STEPS  = 32;
   localparam int unsigned SQRT_STEPS = 16;
   localparam int unsigned NORM_STEPS = 15;
   // S0..S4, divider, square root, four mixing stages, normalizer, output
   localparam int unsigned LATENCY    =
      5 + (DIV_STEPS + 1) + (SQRT_STEPS + 1) + 4 + (NORM_STEPS + 1) + 1;

   // ------------------------------------------------------------------------
   // Configuration registers and their squares
   // ------------------------------------------------------------------------
   logic [14:0] deadband_ff;
   logic [14:0] limit_ff;
   logic [29:0] db_sq_ff;
   logic [29:0] lim_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= mwm_pkg::DEADBAND_RESET;
         limit_ff    <= mwm_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mwm_pkg::CSR_DEADBAND_LEVEL:  deadband_ff <= csr_wdata;
            mwm_pkg::CSR_MAGNITUDE_LIMIT: limit_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // squares must stay static while items are in flight; the user ensures this, the block does not enforce it
   always_ff @(posedge clock) begin
      db_sq_ff  <= 30'(deadband_ff) * 30'(deadband_ff);
      lim_sq_ff <= 30'(limit_ff) * 30'(limit_ff);
   end

   // ------------------------------------------------------------------------
   // Flow control: the pipeline moves as one
   // ------------------------------------------------------------------------
   logic               adv;
   logic [LATENCY-1:0] valid_ff;

   assign adv       = !valid_ff[LATENCY-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LATENCY-2:0], req_valid};
      end
   end

   // ------------------------------------------------------------------------
   // Front end: input register, magnitudes, squares, deadband and limit tests
   // ------------------------------------------------------------------------
   logic [15:0] x0_ff, y0_ff, t0_ff;

   logic [16:0] ax1_ff, ay1_ff, ax1_in, ay1_in;
   logic [16:0] sd1_ff [mwm_pkg::LANES];
   logic [16:0] sd1_in [mwm_pkg::LANES];
   logic [15:0] t1_ff;

   logic [30:0] sx2_ff, sy2_ff, sx2_in, sy2_in;
   logic [33:0] sx_full, sy_full;
   logic [16:0] ap2_ff [mwm_pkg::LANES];
   logic [16:0] ap2_in [mwm_pkg::LANES];
   mwm_pkg::side_type side2_ff, side2_in;

   logic [31:0] s3_ff, s3_in;
   logic [32:0] sq3_ff [mwm_pkg::LANES];
   logic [32:0] sq3_in [mwm_pkg::LANES];
   logic [33:0] sq_full [mwm_pkg::LANES];
   mwm_pkg::side_type side3_ff;

   logic        zero4_ff, zero4_in, clamp4_ff, clamp4_in;
   logic [31:0] s4_ff;
   logic [47:0] pl4_ff [mwm_pkg::LANES];
   logic [47:0] ph4_ff [mwm_pkg::LANES];
   logic [47:0] pl4_in [mwm_pkg::LANES];
   logic [47:0] ph4_in [mwm_pkg::LANES];
   logic [32:0] sq4_ff [mwm_pkg::LANES];
   mwm_pkg::side_type side4_ff;

   // S1: absolute values, diagonal sums
   always_comb begin
      ax1_in = x0_ff[15] ? (17'd0 - {x0_ff[15], x0_ff}) : {1'b0, x0_ff};
      ay1_in = y0_ff[15] ? (17'd0 - {y0_ff[15], y0_ff}) : {1'b0, y0_ff};
      sd1_in[0] = {x0_ff[15], x0_ff} + {y0_ff[15], y0_ff};
      sd1_in[1] = {y0_ff[15], y0_ff} - {x0_ff[15], x0_ff};
   end

   // S2: squares of x and y, magnitudes of the diagonal sums
   always_comb begin
      sx_full = 34'(ax1_ff) * 34'(ax1_ff);
      sy_full = 34'(ay1_ff) * 34'(ay1_ff);
      sx2_in  = sx_full[30:0];
      sy2_in  = sy_full[30:0];
      for (int l = 0; l < mwm_pkg::LANES; l++) begin
         ap2_in[l] = sd1_ff[l][16] ? (17'd0 - sd1_ff[l]) : sd1_ff[l];
      end
      side2_in.turn  = t1_ff;
      side2_in.neg_p = sd1_ff[0][16];
      side2_in.neg_q = sd1_ff[1][16];
   end

   // S3: squared magnitude, squared diagonal sums
   always_comb begin
      s3_in = {1'b0, sx2_ff} + {1'b0, sy2_ff};
      for (int l = 0; l < mwm_pkg::LANES; l++) begin
         sq_full[l] = 34'(ap2_ff[l]) * 34'(ap2_ff[l]);
         sq3_in[l]  = sq_full[l][32:0];
      end
   end

   // S4: deadband and limit tests, split product sq * limit^2
   always_comb begin
      zero4_in  = s3_ff < {2'b00, db_sq_ff};
      clamp4_in = !zero4_in && (s3_ff > {2'b00, lim_sq_ff});
      for (int l = 0; l < mwm_pkg::LANES; l++) begin
         pl4_in[l] = 48'(sq3_ff[l]) * 48'(lim_sq_ff[14:0]);
         ph4_in[l] = 48'(sq3_ff[l]) * 48'(lim_sq_ff[29:15]);
      end
   end

   // ------------------------------------------------------------------------
   // Divider: num / den, one quotient bit per stage.
   // Clamped: num = sq * limit^2, den = 2s. Otherwise den = 2 (halving).
   // ------------------------------------------------------------------------
   logic [32:0] dv_rem_ff [mwm_pkg::LANES][DIV_STEPS+1];
   logic [32:0] dv_rem_in [mwm_pkg::LANES][DIV_STEPS+1];
   logic [31:0] dv_lo_ff  [mwm_pkg::LANES][DIV_STEPS+1];
   logic [31:0] dv_lo_in  [mwm_pkg::LANES][DIV_STEPS+1];
   logic [31:0] dv_quo_ff [mwm_pkg::LANES][DIV_STEPS+1];
   logic [31:0] dv_quo_in [mwm_pkg::LANES][DIV_STEPS+1];
   logic [32:0] dv_den_ff [DIV_STEPS+1];
   logic [32:0] dv_den_in [DIV_STEPS+1];
   mwm_pkg::side_type dv_side_ff [DIV_STEPS+1];
   mwm_pkg::side_type dv_side_in [DIV_STEPS+1];

   always_comb begin : dv_next
      logic [62:0] prod;
      logic [62:0] num;
      logic [33:0] sh;
      dv_den_in[0]  = clamp4_ff ? {s4_ff, 1'b0} : 33'd2;
      dv_side_in[0] = side4_ff;
      for (int l = 0; l < mwm_pkg::LANES; l++) begin
         prod = 63'(pl4_ff[l]) + {ph4_ff[l], 15'd0};
         if (zero4_ff) begin
            num = '0;
         end else if (clamp4_ff) begin
            num = prod;
         end else begin
            num = 63'(sq4_ff[l]);
         end
         dv_rem_in[l][0] = {2'b00, num[62:32]};
         dv_lo_in[l][0]  = num[31:0];
         dv_quo_in[l][0] = '0;
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         dv_den_in[k+1]  = dv_den_ff[k];
         dv_side_in[k+1] = dv_side_ff[k];
         for (int l = 0; l < mwm_pkg::LANES; l++) begin
            sh = {dv_rem_ff[l][k], dv_lo_ff[l][k][31]};
            if (sh >= {1'b0, dv_den_ff[k]}) begin
               dv_rem_in[l][k+1] = 33'(sh - {1'b0, dv_den_ff[k]});
               dv_quo_in[l][k+1] = {dv_quo_ff[l][k][30:0], 1'b1};
            end else begin
               dv_rem_in[l][k+1] = sh[32:0];
               dv_quo_in[l][k+1] = {dv_quo_ff[l][k][30:0], 1'b0};
            end
            dv_lo_in[l][k+1] = {dv_lo_ff[l][k][30:0], 1'b0};
         end
      end
   end

   // ------------------------------------------------------------------------
   // Square root: one root bit per stage
   // ------------------------------------------------------------------------
   logic [31:0] sq_rad_ff  [mwm_pkg::LANES][SQRT_STEPS+1];
   logic [31:0] sq_rad_in  [mwm_pkg::LANES][SQRT_STEPS+1];
   logic [15:0] sq_root_ff [mwm_pkg::LANES][SQRT_STEPS+1];
   logic [15:0] sq_root_in [mwm_pkg::LANES][SQRT_STEPS+1];
   logic [16:0] sq_rem_ff  [mwm_pkg::LANES][SQRT_STEPS+1];
   logic [16:0] sq_rem_in  [mwm_pkg::LANES][SQRT_STEPS+1];
   mwm_pkg::side_type sq_side_ff [SQRT_STEPS+1];
   mwm_pkg::side_type sq_side_in [SQRT_STEPS+1];

   always_comb begin : sq_next
      logic [18:0] sh;
      logic [18:0] trial;
      sq_side_in[0] = dv_side_ff[DIV_STEPS];
      for (int l = 0; l < mwm_pkg::LANES; l++) begin
         sq_rad_in[l][0]  = dv_quo_ff[l][DIV_STEPS];
         sq_root_in[l][0] = '0;
         sq_rem_in[l][0]  = '0;
      end
      for (int k = 0; k < SQRT_STEPS; k++) begin
         sq_side_in[k+1] = sq_side_ff[k];
         for (int l = 0; l < mwm_pkg::LANES; l++) begin
            sh    = {sq_rem_ff[l][k], sq_rad_ff[l][k][31:30]};
            trial = {1'b0, sq_root_ff[l][k], 2'b01};
            if (sh >= trial) begin
               sq_rem_in[l][k+1]  = 17'(sh - trial);
               sq_root_in[l][k+1] = {sq_root_ff[l][k][14:0], 1'b1};
            end else begin
               sq_rem_in[l][k+1]  = sh[16:0];
               sq_root_in[l][k+1] = {sq_root_ff[l][k][14:0], 1'b0};
            end
            sq_rad_in[l][k+1] = {sq_rad_ff[l][k][29:0], 2'b00};
         end
      end
   end

   // ------------------------------------------------------------------------
   // Mixing: signed diagonals, turn added, magnitudes, largest magnitude
   // ------------------------------------------------------------------------
   logic [17:0] pa_ff [mwm_pkg::LANES];
   logic [17:0] pa_in [mwm_pkg::LANES];
   logic [15:0] ta_ff;

   logic [17:0] wb_ff [mwm_pkg::WHEELS];
   logic [17:0] wb_in [mwm_pkg::WHEELS];
   logic [17:0] t_ext;

   logic [16:0] ac_ff [mwm_pkg::WHEELS];
   logic [16:0] ac_in [mwm_pkg::WHEELS];
   logic [15:0] vc_ff [mwm_pkg::WHEELS];
   logic        nc_ff [mwm_pkg::WHEELS];

   logic [16:0] ad_ff [mwm_pkg::WHEELS];
   logic [15:0] vd_ff [mwm_pkg::WHEELS];
   logic        nd_ff [mwm_pkg::WHEELS];
   logic [16:0] m01_ff, m23_ff, m01_in, m23_in;

   // A: apply sign to the root
   always_comb begin
      for (int l = 0; l < mwm_pkg::LANES; l++) begin
         pa_in[l] = {2'b00, sq_root_ff[l][SQRT_STEPS]};
      end
      if (sq_side_ff[SQRT_STEPS].neg_p) pa_in[0] = 18'd0 - pa_in[0];
      if (sq_side_ff[SQRT_STEPS].neg_q) pa_in[1] = 18'd0 - pa_in[1];
   end

   // B: lf = p + t, lb = q + t, rf = q - t, rb = p - t
   always_comb begin
      t_ext    = {{2{ta_ff[15]}}, ta_ff};
      wb_in[0] = pa_ff[0] + t_ext;
      wb_in[1] = pa_ff[1] + t_ext;
      wb_in[2] = pa_ff[1] - t_ext;
      wb_in[3] = pa_ff[0] - t_ext;
   end

   // C: magnitudes
   always_comb begin
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         ac_in[i] = wb_ff[i][17] ? 17'(18'd0 - wb_ff[i]) : wb_ff[i][16:0];
      end
   end

   // D: pairwise maxima
   always_comb begin
      m01_in = (ac_ff[0] >= ac_ff[1]) ? ac_ff[0] : ac_ff[1];
      m23_in = (ac_ff[2] >= ac_ff[3]) ? ac_ff[2] : ac_ff[3];
   end

   // ------------------------------------------------------------------------
   // Normalizer: |v| * 1.0 / big, one quotient bit per stage, when big > 1.0
   // ------------------------------------------------------------------------
   logic [16:0] nm_rem_ff [mwm_pkg::WHEELS][NORM_STEPS+1];
   logic [16:0] nm_rem_in [mwm_pkg::WHEELS][NORM_STEPS+1];
   logic [14:0] nm_lo_ff  [mwm_pkg::WHEELS][NORM_STEPS+1];
   logic [14:0] nm_lo_in  [mwm_pkg::WHEELS][NORM_STEPS+1];
   logic [14:0] nm_quo_ff [mwm_pkg::WHEELS][NORM_STEPS+1];
   logic [14:0] nm_quo_in [mwm_pkg::WHEELS][NORM_STEPS+1];
   logic [15:0] nm_v_ff   [mwm_pkg::WHEELS][NORM_STEPS+1];
   logic [15:0] nm_v_in   [mwm_pkg::WHEELS][NORM_STEPS+1];
   logic        nm_neg_ff [mwm_pkg::WHEELS][NORM_STEPS+1];
   logic        nm_neg_in [mwm_pkg::WHEELS][NORM_STEPS+1];
   logic [16:0] nm_big_ff [NORM_STEPS+1];
   logic [16:0] nm_big_in [NORM_STEPS+1];
   logic        nm_byp_ff [NORM_STEPS+1];
   logic        nm_byp_in [NORM_STEPS+1];

   always_comb begin : nm_next
      logic [17:0] sh;
      nm_big_in[0] = (m01_ff >= m23_ff) ? m01_ff : m23_ff;
      nm_byp_in[0] = nm_big_in[0] <= mwm_pkg::ONE_Q14;
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         // numerator is |v| << 14: start with its top bits
         nm_rem_in[i][0] = {1'b0, ad_ff[i][16:1]};
         nm_lo_in[i][0]  = {ad_ff[i][0], 14'd0};
         nm_quo_in[i][0] = '0;
         nm_v_in[i][0]   = vd_ff[i];
         nm_neg_in[i][0] = nd_ff[i];
      end
      for (int k = 0; k < NORM_STEPS; k++) begin
         nm_big_in[k+1] = nm_big_ff[k];
         nm_byp_in[k+1] = nm_byp_ff[k];
         for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
            sh = {nm_rem_ff[i][k], nm_lo_ff[i][k][14]};
            if (sh >= {1'b0, nm_big_ff[k]}) begin
               nm_rem_in[i][k+1] = 17'(sh - {1'b0, nm_big_ff[k]});
               nm_quo_in[i][k+1] = {nm_quo_ff[i][k][13:0], 1'b1};
            end else begin
               nm_rem_in[i][k+1] = sh[16:0];
               nm_quo_in[i][k+1] = {nm_quo_ff[i][k][13:0], 1'b0};
            end
            nm_lo_in[i][k+1]  = {nm_lo_ff[i][k][13:0], 1'b0};
            nm_v_in[i][k+1]   = nm_v_ff[i][k];
            nm_neg_in[i][k+1] = nm_neg_ff[i][k];
         end
      end
   end

   // output: pass through, or signed quotient
   logic [15:0] out_ff [mwm_pkg::WHEELS];
   logic [15:0] out_in [mwm_pkg::WHEELS];

   always_comb begin
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         if (nm_byp_ff[NORM_STEPS]) begin
            out_in[i] = nm_v_ff[i][NORM_STEPS];
         end else if (nm_neg_ff[i][NORM_STEPS]) begin
            out_in[i] = 16'd0 - {1'b0, nm_quo_ff[i][NORM_STEPS]};
         end else begin
            out_in[i] = {1'b0, nm_quo_ff[i][NORM_STEPS]};
         end
      end
   end

   assign rsp_left_front_speed  = out_ff[0];
   assign rsp_left_back_speed   = out_ff[1];
   assign rsp_right_front_speed = out_ff[2];
   assign rsp_right_back_speed  = out_ff[3];

   // ------------------------------------------------------------------------
   // Payload registers, all advancing together
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff <= req_strafe_cmd;
         y0_ff <= req_forward_cmd;
         t0_ff <= req_turn_cmd;

         ax1_ff <= ax1_in;
         ay1_ff <= ay1_in;
         sd1_ff <= sd1_in;
         t1_ff  <= t0_ff;

         sx2_ff   <= sx2_in;
         sy2_ff   <= sy2_in;
         ap2_ff   <= ap2_in;
         side2_ff <= side2_in;

         s3_ff    <= s3_in;
         sq3_ff   <= sq3_in;
         side3_ff <= side2_ff;

         zero4_ff  <= zero4_in;
         clamp4_ff <= clamp4_in;
         s4_ff     <= s3_ff;
         pl4_ff    <= pl4_in;
         ph4_ff    <= ph4_in;
         sq4_ff    <= sq3_ff;
         side4_ff  <= side3_ff;

         dv_rem_ff  <= dv_rem_in;
         dv_lo_ff   <= dv_lo_in;
         dv_quo_ff  <= dv_quo_in;
         dv_den_ff  <= dv_den_in;
         dv_side_ff <= dv_side_in;

         sq_rad_ff  <= sq_rad_in;
         sq_root_ff <= sq_root_in;
         sq_rem_ff  <= sq_rem_in;
         sq_side_ff <= sq_side_in;

         pa_ff <= pa_in;
         ta_ff <= sq_side_ff[SQRT_STEPS].turn;

         wb_ff <= wb_in;

         ac_ff <= ac_in;
         for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
            vc_ff[i] <= wb_ff[i][15:0];
            nc_ff[i] <= wb_ff[i][17];
         end

         ad_ff  <= ac_ff;
         vd_ff  <= vc_ff;
         nd_ff  <= nc_ff;
         m01_ff <= m01_in;
         m23_ff <= m23_in;

         nm_rem_ff <= nm_rem_in;
         nm_lo_ff  <= nm_lo_in;
         nm_quo_ff <= nm_quo_in;
         nm_v_ff   <= nm_v_in;
         nm_neg_ff <= nm_neg_in;
         nm_big_ff <= nm_big_in;
         nm_byp_ff <= nm_byp_in;

         out_ff <= out_in;
      end
   end

endmodule
